// File: src/pll_bus_clock_divider_search_top_assert.svh
// assertion macros for the bus clock divider search checker
// no dependencies; included by the checker file only
`ifndef PLL_BUS_CLOCK_DIVIDER_SEARCH_TOP_ASSERT_SVH
`define PLL_BUS_CLOCK_DIVIDER_SEARCH_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PBCDS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define PBCDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: src/pbcds_pkg.sv
// shared constants and helpers for the bus clock divider search
// no dependencies
`default_nettype none

package pbcds_pkg;

   localparam int REF_W      = 26;
   localparam int FB_W       = 5;
   localparam int CODE_W     = 10;
   localparam int SYS_W      = 31;
   localparam int HZ_W       = 28;
   localparam int MHZ_W      = 12;
   localparam int QUO_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 28;

   localparam int DIV_CODE_MAX_DEF = 1023;

   localparam logic [19:0]       MHZ_TO_HZ     = 20'd1000000;
   localparam logic [CODE_W-1:0] CODE_FIRST    = 10'd3;
   localparam logic [FB_W-1:0]   FBDIV_MIN_RST = 5'd20;
   localparam logic [FB_W-1:0]   FBDIV_MAX_RST = 5'd27;
   localparam logic [HZ_W-1:0]   MAX_BUS_RST   = 28'd100000000;

   localparam logic [CSR_IDX_W-1:0] CSR_REF_SELECT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_HALVE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_DIV    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FBDIV_MIN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FBDIV_MAX  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BUS    = 3'd5;

   typedef logic [REF_W-1:0] ref_hz_type;

   // reference oscillator frequency in Hz
   function automatic ref_hz_type ref_hz(input logic [1:0] sel);
      ref_hz_type hz;
      case (sel)
         2'd0:    hz = 26'd19200000;
         2'd1:    hz = 26'd26000000;
         2'd2:    hz = 26'd38400000;
         2'd3:    hz = 26'd52000000;
         default: hz = 26'd19200000;
      endcase
      return hz;
   endfunction

endpackage

`default_nettype wire

// File: src/pll_bus_clock_divider_search_top.sv
// bus clock divider search: sequencer, shared multiplier and radix-2 divider
// depends on pbcds_pkg
`default_nettype none

// One request (a target in MHz) yields one response. The search walks the
// feedback divider from fbdiv_max down to fbdiv_min and, for each, the odd bus
// divider codes 3..DIV_CODE_MAX. Each code costs one pass of a shared 32-bit
// restoring divider at one quotient bit per cycle, plus one compare step. Up to
// 511 codes are scanned per feedback divider, fewer when an exact match ends
// that divider's scan; the reset range holds eight feedback dividers. req_stall
// is high for the whole search. The response sits in an output register, so a
// new request is taken while it waits. Configuration must be written only while
// idle; the block itself does not enforce this.
module pll_bus_clock_divider_search_top #(
   parameter int DIV_CODE_MAX = pbcds_pkg::DIV_CODE_MAX_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_write_enable,
   input  wire  [pbcds_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [pbcds_pkg::CSR_DATA_W-1:0]    csr_data,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire  [pbcds_pkg::MHZ_W-1:0]         req_target_mhz,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic [pbcds_pkg::FB_W-1:0]          rsp_best_fbdiv,
   output logic [pbcds_pkg::CODE_W-1:0]        rsp_bus_div_code,
   output logic [pbcds_pkg::SYS_W-1:0]         rsp_sys_clk_hz,
   output logic [pbcds_pkg::HZ_W-1:0]          rsp_bus_clk_hz
);

   localparam int FB_W   = pbcds_pkg::FB_W;
   localparam int CODE_W = pbcds_pkg::CODE_W;
   localparam int SYS_W  = pbcds_pkg::SYS_W;
   localparam int HZ_W   = pbcds_pkg::HZ_W;
   localparam int QUO_W  = pbcds_pkg::QUO_W;
   localparam int REF_W  = pbcds_pkg::REF_W;

   localparam logic [CODE_W:0] CODE_LAST = (CODE_W+1)'(DIV_CODE_MAX);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOAD   = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_EVAL   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   // configuration
   logic [1:0]      ref_select_ff, ref_select_in;
   logic            ref_halve_ff, ref_halve_in;
   logic [1:0]      out_div_ff, out_div_in;
   logic [FB_W-1:0] fbdiv_min_ff, fbdiv_min_in;
   logic [FB_W-1:0] fbdiv_max_ff, fbdiv_max_in;
   logic [HZ_W-1:0] max_bus_ff, max_bus_in;

   // control
   logic [2:0]      state_ff, state_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // search datapath
   logic [HZ_W-1:0]   target_ff, target_in;
   logic [FB_W-1:0]   fb_ff, fb_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic [QUO_W-1:0]  sys2_ff, sys2_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [CODE_W:0]   rem_ff, rem_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic              best_valid_ff, best_valid_in;
   logic [HZ_W-1:0]   best_err_ff, best_err_in;
   logic [FB_W-1:0]   best_fb_ff, best_fb_in;
   logic [CODE_W-1:0] best_code_ff, best_code_in;
   logic [HZ_W-1:0]   best_bus_ff, best_bus_in;

   // response
   logic [FB_W-1:0]   rsp_fb_ff, rsp_fb_in;
   logic [CODE_W-1:0] rsp_code_ff, rsp_code_in;
   logic [SYS_W-1:0]  rsp_sys_ff, rsp_sys_in;
   logic [HZ_W-1:0]   rsp_bus_ff, rsp_bus_in;

   // shared sysclk multiplier
   logic [REF_W-1:0]       ref_eff;
   logic [FB_W-1:0]        mul_fb;
   logic [REF_W+FB_W-1:0]  mul_prod;
   logic [SYS_W-1:0]       sysclk;

   // target scaling
   logic [pbcds_pkg::MHZ_W-1:0] mhz_eff;
   logic [QUO_W-1:0]            scaled_hz;

   // divider step
   logic [CODE_W:0]   divisor;
   logic [CODE_W+1:0] trial;
   logic              trial_ge;
   logic [CODE_W+1:0] trial_sub;

   // candidate compare
   logic [HZ_W-1:0] bus_hz;
   logic            qualifies;
   logic [HZ_W-1:0] err;
   logic            better;
   logic            code_done;
   logic            out_free;

   assign ref_eff  = ref_halve_ff ? (pbcds_pkg::ref_hz(ref_select_ff) >> 1)
                                  : pbcds_pkg::ref_hz(ref_select_ff);
   assign mul_fb   = (state_ff == ST_FINISH) ? best_fb_ff : fb_ff;
   assign mul_prod = ref_eff * mul_fb;
   assign sysclk   = SYS_W'(mul_prod >> out_div_ff);

   assign mhz_eff   = (req_target_mhz == '0) ? pbcds_pkg::MHZ_W'(1) : req_target_mhz;
   assign scaled_hz = QUO_W'(mhz_eff) * QUO_W'(pbcds_pkg::MHZ_TO_HZ);

   assign divisor   = {1'b0, code_ff} + (CODE_W+1)'(1);
   assign trial     = {rem_ff, quo_ff[QUO_W-1]};
   assign trial_ge  = trial >= {1'b0, divisor};
   assign trial_sub = trial - {1'b0, divisor};

   assign bus_hz    = quo_ff[HZ_W-1:0];
   assign qualifies = quo_ff <= {{(QUO_W-HZ_W){1'b0}}, max_bus_ff};
   assign err       = (bus_hz >= target_ff) ? (bus_hz - target_ff) : (target_ff - bus_hz);
   assign better    = qualifies && (!best_valid_ff || (err < best_err_ff));
   assign code_done = (qualifies && (err == '0))
                      || (({1'b0, code_ff} + (CODE_W+1)'(2)) > CODE_LAST);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_best_fbdiv   = rsp_fb_ff;
   assign rsp_bus_div_code = rsp_code_ff;
   assign rsp_sys_clk_hz   = rsp_sys_ff;
   assign rsp_bus_clk_hz   = rsp_bus_ff;

   always_comb begin
      ref_select_in = ref_select_ff;
      ref_halve_in  = ref_halve_ff;
      out_div_in    = out_div_ff;
      fbdiv_min_in  = fbdiv_min_ff;
      fbdiv_max_in  = fbdiv_max_ff;
      max_bus_in    = max_bus_ff;
      if (csr_write_enable) begin
         case (csr_index)
            pbcds_pkg::CSR_REF_SELECT: ref_select_in = csr_data[1:0];
            pbcds_pkg::CSR_REF_HALVE:  ref_halve_in  = csr_data[0];
            pbcds_pkg::CSR_OUT_DIV:    out_div_in    = csr_data[1:0];
            pbcds_pkg::CSR_FBDIV_MIN:  fbdiv_min_in  = csr_data[FB_W-1:0];
            pbcds_pkg::CSR_FBDIV_MAX:  fbdiv_max_in  = csr_data[FB_W-1:0];
            pbcds_pkg::CSR_MAX_BUS:    max_bus_in    = csr_data[HZ_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      target_in     = target_ff;
      fb_in         = fb_ff;
      code_in       = code_ff;
      sys2_in       = sys2_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      best_valid_in = best_valid_ff;
      best_err_in   = best_err_ff;
      best_fb_in    = best_fb_ff;
      best_code_in  = best_code_ff;
      best_bus_in   = best_bus_ff;
      rsp_fb_in     = rsp_fb_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_sys_in    = rsp_sys_ff;
      rsp_bus_in    = rsp_bus_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               target_in     = (scaled_hz > {{(QUO_W-HZ_W){1'b0}}, max_bus_ff})
                               ? max_bus_ff : scaled_hz[HZ_W-1:0];
               fb_in         = fbdiv_max_ff;
               best_valid_in = 1'b0;
               best_err_in   = '0;
               best_fb_in    = fbdiv_min_ff;
               best_code_in  = pbcds_pkg::CODE_FIRST;
               best_bus_in   = '0;
               state_in      = (fbdiv_min_ff > fbdiv_max_ff) ? ST_FINISH : ST_LOAD;
            end
         end
         ST_LOAD: begin
            sys2_in  = {sysclk, 1'b0};
            quo_in   = {sysclk, 1'b0};
            rem_in   = '0;
            cnt_in   = '0;
            code_in  = pbcds_pkg::CODE_FIRST;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = trial_ge ? trial_sub[CODE_W:0] : trial[CODE_W:0];
            quo_in = {quo_ff[QUO_W-2:0], trial_ge};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (better) begin
               best_valid_in = 1'b1;
               best_err_in   = err;
               best_fb_in    = fb_ff;
               best_code_in  = code_ff;
               best_bus_in   = bus_hz;
            end
            if (!code_done) begin
               code_in  = code_ff + CODE_W'(2);
               quo_in   = sys2_ff;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end else if (fb_ff == fbdiv_min_ff) begin
               state_in = ST_FINISH;
            end else begin
               fb_in    = fb_ff - FB_W'(1);
               state_in = ST_LOAD;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_fb_in    = best_fb_ff;
               rsp_code_in  = best_code_ff;
               rsp_sys_in   = sysclk;
               rsp_bus_in   = best_bus_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         ref_select_ff <= 2'd0;
         ref_halve_ff  <= 1'b0;
         out_div_ff    <= 2'd0;
         fbdiv_min_ff  <= pbcds_pkg::FBDIV_MIN_RST;
         fbdiv_max_ff  <= pbcds_pkg::FBDIV_MAX_RST;
         max_bus_ff    <= pbcds_pkg::MAX_BUS_RST;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         ref_select_ff <= ref_select_in;
         ref_halve_ff  <= ref_halve_in;
         out_div_ff    <= out_div_in;
         fbdiv_min_ff  <= fbdiv_min_in;
         fbdiv_max_ff  <= fbdiv_max_in;
         max_bus_ff    <= max_bus_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff     <= target_in;
      fb_ff         <= fb_in;
      code_ff       <= code_in;
      sys2_ff       <= sys2_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      best_valid_ff <= best_valid_in;
      best_err_ff   <= best_err_in;
      best_fb_ff    <= best_fb_in;
      best_code_ff  <= best_code_in;
      best_bus_ff   <= best_bus_in;
      rsp_fb_ff     <= rsp_fb_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_sys_ff    <= rsp_sys_in;
      rsp_bus_ff    <= rsp_bus_in;
   end

endmodule

`default_nettype wire

// File: src/pbcds_check.sv
// port-level checker for the bus clock divider search, bound to the top level
// depends on pbcds_pkg and pll_bus_clock_divider_search_top_assert.svh
`default_nettype none

`include "pll_bus_clock_divider_search_top_assert.svh"

module pbcds_check (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_valid,
   input wire                              req_stall,
   input wire                              rsp_valid,
   input wire                              rsp_stall,
   input wire [pbcds_pkg::CODE_W-1:0]      rsp_bus_div_code,
   input wire [pbcds_pkg::HZ_W-1:0]        rsp_bus_clk_hz
);

   // a response waiting on the consumer stays valid
   `PBCDS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // an accepted request keeps the block busy in the next cycle
   `PBCDS_ASSERT_NEXT(a_req_busy, clock, reset, req_valid && !req_stall, req_stall)

   // a valid response's divider code is always odd and at least three
   `PBCDS_ASSERT_NOW(a_code_odd, clock, reset, rsp_valid,
                     rsp_bus_div_code[0] && (rsp_bus_div_code >= 10'd3))

   // a fresh response never appears while the block still takes requests
   `PBCDS_ASSERT_NEXT(a_rsp_done, clock, reset, !rsp_valid && !req_stall, !rsp_valid)

   // a waiting response keeps its payload
   `PBCDS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall,
                      $stable(rsp_bus_div_code) && $stable(rsp_bus_clk_hz))

endmodule

bind pll_bus_clock_divider_search_top pbcds_check u_pbcds_check (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_bus_div_code (rsp_bus_div_code),
   .rsp_bus_clk_hz   (rsp_bus_clk_hz)
);

`default_nettype wire

// File: test/pll_bus_clock_divider_search_checker.sv
// response checker for the bus clock divider search: mirrors the registers,
// predicts the divider choice for every accepted request and compares responses
// depends on pbcds_pkg
`timescale 1ns / 100ps

module pll_bus_clock_divider_search_checker #(
   parameter int DIV_CODE_MAX = pbcds_pkg::DIV_CODE_MAX_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_write_enable,
   input  wire  [pbcds_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [pbcds_pkg::CSR_DATA_W-1:0]    csr_data,
   input  wire                                 req_valid,
   input  wire                                 req_stall,
   input  wire  [pbcds_pkg::MHZ_W-1:0]         req_target_mhz,
   input  wire                                 rsp_valid,
   input  wire                                 rsp_stall,
   input  wire  [pbcds_pkg::FB_W-1:0]          rsp_best_fbdiv,
   input  wire  [pbcds_pkg::CODE_W-1:0]        rsp_bus_div_code,
   input  wire  [pbcds_pkg::SYS_W-1:0]         rsp_sys_clk_hz,
   input  wire  [pbcds_pkg::HZ_W-1:0]          rsp_bus_clk_hz,
   output int                                  mismatch_count,
   output int                                  pending_count
);
   import pbcds_pkg::*;

   localparam logic [1:0] REF_SEL_19M2 = 2'd0;
   localparam logic [1:0] REF_SEL_26M  = 2'd1;
   localparam logic [1:0] REF_SEL_38M4 = 2'd2;
   localparam logic [1:0] REF_SEL_52M  = 2'd3;

   localparam logic [63:0] REF_19M2_HZ = 64'd19200000;
   localparam logic [63:0] REF_26M_HZ  = 64'd26000000;
   localparam logic [63:0] REF_38M4_HZ = 64'd38400000;
   localparam logic [63:0] REF_52M_HZ  = 64'd52000000;
   localparam logic [63:0] NO_ERR_YET  = 64'hFFFFFFFF;

   typedef struct packed {
      logic [FB_W-1:0]   fbdiv;
      logic [CODE_W-1:0] div_code;
      logic [SYS_W-1:0]  sys_hz;
      logic [HZ_W-1:0]   bus_hz;
   } bus_setting_type;

   logic [1:0]      ref_sel;
   logic            ref_halve;
   logic [1:0]      out_div;
   logic [FB_W-1:0] fb_lo;
   logic [FB_W-1:0] fb_hi;
   logic [HZ_W-1:0] bus_limit;

   bus_setting_type predicted_settings[$];
   int              errs = 0;
   int              rsp_index = 0;

   function automatic logic [63:0] pll_sys_hz(input logic [FB_W-1:0] fb);
      logic [63:0] base;
      case (ref_sel)
         REF_SEL_19M2: base = REF_19M2_HZ;
         REF_SEL_26M:  base = REF_26M_HZ;
         REF_SEL_38M4: base = REF_38M4_HZ;
         default:      base = REF_52M_HZ;
      endcase
      if (ref_halve) base = base >> 1;
      return (base * 64'(fb)) >> out_div;
   endfunction

   function automatic bus_setting_type search_dividers(input logic [MHZ_W-1:0] mhz);
      bus_setting_type best;
      logic [63:0]  target;
      logic [63:0]  best_err;
      logic [63:0]  twice;
      logic [63:0]  bus;
      logic [63:0]  err;
      logic [FB_W-1:0] fb;
      logic         exact;
      logic         done;
      int           code;
      target = (mhz == 0) ? 64'd1 : 64'(mhz);
      target = target * 64'd1000000;
      if (target > 64'(bus_limit)) target = 64'(bus_limit);
      best_err = NO_ERR_YET;
      best.fbdiv = fb_lo;
      best.div_code = CODE_FIRST;
      best.bus_hz = '0;
      if (fb_lo <= fb_hi) begin
         fb = fb_hi;
         done = 1'b0;
         while (!done) begin
            twice = pll_sys_hz(fb) << 1;
            exact = 1'b0;
            for (code = 3; code <= DIV_CODE_MAX && !exact; code += 2) begin
               bus = twice / 64'(code + 1);
               if (bus <= 64'(bus_limit)) begin
                  err = (bus > target) ? bus - target : target - bus;
                  if (err < best_err) begin
                     best_err = err;
                     best.fbdiv = fb;
                     best.div_code = code[CODE_W-1:0];
                     best.bus_hz = bus[HZ_W-1:0];
                  end
                  if (err == 64'd0) exact = 1'b1;
               end
            end
            if (fb == fb_lo) done = 1'b1;
            else fb = fb - 1'b1;
         end
      end
      best.sys_hz = SYS_W'(pll_sys_hz(best.fbdiv));
      return best;
   endfunction

   always @(posedge clock) begin
      bus_setting_type want;
      if (reset) begin
         ref_sel   = 2'd0;
         ref_halve = 1'b0;
         out_div   = 2'd0;
         fb_lo     = FBDIV_MIN_RST;
         fb_hi     = FBDIV_MAX_RST;
         bus_limit = MAX_BUS_RST;
         predicted_settings.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_REF_SELECT: ref_sel   = csr_data[1:0];
               CSR_REF_HALVE:  ref_halve = csr_data[0];
               CSR_OUT_DIV:    out_div   = csr_data[1:0];
               CSR_FBDIV_MIN:  fb_lo     = csr_data[FB_W-1:0];
               CSR_FBDIV_MAX:  fb_hi     = csr_data[FB_W-1:0];
               CSR_MAX_BUS:    bus_limit = csr_data[HZ_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_settings.size() == 0) begin
               errs++;
               if (errs <= 10)
                  $display("response %0d arrived with no request waiting", rsp_index);
            end else begin
               want = predicted_settings.pop_front();
               if (rsp_best_fbdiv !== want.fbdiv || rsp_bus_div_code !== want.div_code ||
                   rsp_sys_clk_hz !== want.sys_hz || rsp_bus_clk_hz !== want.bus_hz) begin
                  errs++;
                  if (errs <= 10) begin
                     $display("response %0d mismatch: expected fbdiv %0d code %0d sys %0d bus %0d",
                              rsp_index, want.fbdiv, want.div_code, want.sys_hz,
                              want.bus_hz);
                     $display("   got fbdiv %0d code %0d sys %0d bus %0d",
                              rsp_best_fbdiv, rsp_bus_div_code, rsp_sys_clk_hz,
                              rsp_bus_clk_hz);
                  end
               end
            end
            rsp_index++;
         end
         if (req_valid && !req_stall)
            predicted_settings.push_back(search_dividers(req_target_mhz));
      end
      mismatch_count <= errs;
      pending_count  <= predicted_settings.size();
   end

endmodule

// File: test/pll_bus_clock_divider_search_top_tb.sv
// testbench top for the bus clock divider search: clock, reset, register
// setups, directed and random requests, random stalls and the final verdict
// depends on pbcds_pkg, pll_bus_clock_divider_search_top and the checker
`timescale 1ns / 100ps

module pll_bus_clock_divider_search_top_tb;
   import pbcds_pkg::*;

   localparam int DIV_CODE_MAX    = DIV_CODE_MAX_DEF;
   localparam int CODES_PER_FB    = (DIV_CODE_MAX - 3) / 2 + 1;
   localparam int RANDOM_REQUESTS = 100;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   logic                  req_valid = 1'b0;
   logic [MHZ_W-1:0]      req_target_mhz = '0;
   logic                  rsp_stall = 1'b0;
   wire                   req_stall;
   wire                   rsp_valid;
   wire  [FB_W-1:0]       rsp_best_fbdiv;
   wire  [CODE_W-1:0]     rsp_bus_div_code;
   wire  [SYS_W-1:0]      rsp_sys_clk_hz;
   wire  [HZ_W-1:0]       rsp_bus_clk_hz;
   int                    mismatch_count;
   int                    pending_count;

   logic                  quiet = 1'b0;
   longint                cycle_count = 0;
   longint                cycle_budget = 20000;
   logic [FB_W-1:0]       shadow_min = FBDIV_MIN_RST;
   logic [FB_W-1:0]       shadow_max = FBDIV_MAX_RST;
   int                    random_sent;

   always #5 clock = ~clock;

   pll_bus_clock_divider_search_top #(
      .DIV_CODE_MAX(DIV_CODE_MAX)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_target_mhz   (req_target_mhz),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_best_fbdiv   (rsp_best_fbdiv),
      .rsp_bus_div_code (rsp_bus_div_code),
      .rsp_sys_clk_hz   (rsp_sys_clk_hz),
      .rsp_bus_clk_hz   (rsp_bus_clk_hz)
   );

   pll_bus_clock_divider_search_checker #(
      .DIV_CODE_MAX(DIV_CODE_MAX)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_target_mhz   (req_target_mhz),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_best_fbdiv   (rsp_best_fbdiv),
      .rsp_bus_div_code (rsp_bus_div_code),
      .rsp_sys_clk_hz   (rsp_sys_clk_hz),
      .rsp_bus_clk_hz   (rsp_bus_clk_hz),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count)
   );

   initial begin
      while (cycle_count < cycle_budget) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("pll_bus_clock_divider_search_top_tb: errors");
      $finish;
   end

   always begin
      @(posedge clock);
      if (!quiet) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(1, 11)) @(posedge clock);
               rsp_stall <= 1'b0;
            end
            2: repeat ($urandom_range(20, 300)) @(posedge clock);
            default: ;
         endcase
      end
   end

   // unused upper bits carry noise
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value, input int width);
      logic [CSR_DATA_W-1:0] noise;
      noise = CSR_DATA_W'($urandom());
      noise = noise << width;
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= noise | value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_pll(input logic [1:0] rsel, input logic halve,
                              input logic [1:0] odiv, input logic [FB_W-1:0] fmin,
                              input logic [FB_W-1:0] fmax, input logic [HZ_W-1:0] limit);
      drain_responses();
      write_reg(CSR_REF_SELECT, CSR_DATA_W'(rsel), 2);
      write_reg(CSR_REF_HALVE, CSR_DATA_W'(halve), 1);
      write_reg(CSR_OUT_DIV, CSR_DATA_W'(odiv), 2);
      write_reg(CSR_FBDIV_MIN, CSR_DATA_W'(fmin), FB_W);
      write_reg(CSR_FBDIV_MAX, CSR_DATA_W'(fmax), FB_W);
      write_reg(CSR_MAX_BUS, CSR_DATA_W'(limit), HZ_W);
      shadow_min = fmin;
      shadow_max = fmax;
   endtask

   task automatic send_target(input logic [MHZ_W-1:0] mhz);
      int searched;
      searched = (shadow_min <= shadow_max) ? shadow_max - shadow_min + 1 : 0;
      cycle_budget += longint'(4 * (searched * (1 + 33 * CODES_PER_FB) + 300));
      if (!quiet && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_target_mhz <= mhz;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [MHZ_W-1:0] random_target();
      logic [MHZ_W-1:0] mhz;
      case ($urandom_range(0, 3))
         0:       mhz = MHZ_W'($urandom());
         1:       mhz = MHZ_W'($urandom_range(0, 300));
         default: mhz = MHZ_W'($urandom_range(1, 200));
      endcase
      return mhz;
   endfunction

   task automatic program_random();
      logic [FB_W-1:0] fmin;
      logic [FB_W-1:0] fmax;
      logic [HZ_W-1:0] limit;
      int              shape;
      shape = $urandom_range(0, 19);
      if (shape < 14) begin
         fmin = FB_W'($urandom_range(0, 31));
         fmax = fmin;
      end else if (shape < 17) begin
         fmin = FB_W'($urandom_range(1, 31));
         fmax = FB_W'($urandom_range(0, fmin - 1));
      end else begin
         fmin = FB_W'($urandom_range(0, 28));
         fmax = FB_W'(fmin + $urandom_range(1, 3));
      end
      case ($urandom_range(0, 9))
         0:       limit = '0;
         1:       limit = 28'd1;
         2:       limit = '1;
         3:       limit = 28'd200000000;
         4, 5:    limit = HZ_W'($urandom());
         default: limit = HZ_W'($urandom_range(1000000, 200000000));
      endcase
      program_pll(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  2'($urandom_range(0, 3)), fmin, fmax, limit);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers at their reset values, zero target
      send_target(12'd0);
      program_pll(2'd3, 1'b0, 2'd0, 5'd31, 5'd31, 28'd200000000);
      send_target(12'd4095);
      send_target(12'd100);
      program_pll(2'd0, 1'b1, 2'd3, 5'd1, 5'd1, '1);
      send_target(12'd1);
      send_target(12'd2048);
      // exact matches end the code scan
      program_pll(2'd0, 1'b0, 2'd0, 5'd25, 5'd25, '1);
      send_target(12'd120);
      send_target(12'd240);
      send_target(12'd4095);
      // empty divider range
      program_pll(2'd1, 1'b1, 2'd1, 5'd10, 5'd9, 28'd50000000);
      send_target(12'd55);
      send_target(12'd4095);
      // zero minimum divider
      program_pll(2'd2, 1'b0, 2'd2, 5'd0, 5'd2, 28'd100000000);
      send_target(12'd1);
      send_target(12'd77);
      // zero limit
      program_pll(2'd3, 1'b1, 2'd1, 5'd5, 5'd5, 28'd0);
      send_target(12'd3000);
      send_target(12'd0);
      program_pll(2'd0, 1'b0, 2'd0, 5'd0, 5'd0, 28'd0);
      send_target(12'd12);
      // nothing qualifies
      program_pll(2'd0, 1'b1, 2'd3, 5'd1, 5'd1, 28'd1);
      send_target(12'd9);
      // widest divider range
      program_pll(2'd2, 1'b1, 2'd2, 5'd0, 5'd31, 28'd150000000);
      send_target(12'd33);

      random_sent = 0;
      while (random_sent < RANDOM_REQUESTS) begin
         if (random_sent >= RANDOM_REQUESTS * 4 / 5) quiet <= 1'b1;
         program_random();
         repeat ($urandom_range(1, 6)) begin
            send_target(random_target());
            random_sent++;
         end
      end

      drain_responses();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("pll_bus_clock_divider_search_top_tb: clean");
      else
         $display("pll_bus_clock_divider_search_top_tb: errors");
      $finish;
   end

endmodule
